// File: design/bfgr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bfgr_pkg;

   localparam int COORD_BITS = 10;
   localparam int COLOR_BITS = 24;

   // The coordinate sum must hold a coordinate, a signed byte offset and a
   // byte-wide counter without overflowing.
   localparam int SUM_BITS = ((COORD_BITS > 9) ? COORD_BITS : 9) + 2;

   localparam int COORD_MAX = (2 ** (COORD_BITS - 1)) - 1;
   localparam int COORD_MIN = -COORD_MAX - 1;

   localparam logic signed [SUM_BITS-1:0] SUM_HI = SUM_BITS'(COORD_MAX);
   localparam logic signed [SUM_BITS-1:0] SUM_LO = SUM_BITS'(COORD_MIN);

   localparam logic [COORD_BITS-1:0] COORD_HI_CODE = COORD_BITS'(COORD_MAX);
   localparam logic [COORD_BITS-1:0] COORD_LO_CODE = COORD_BITS'(COORD_MIN);

   localparam logic [7:0] BIT_MSB_MASK = 8'h80;
   localparam logic [2:0] LAST_BIT_IDX = 3'd7;

   typedef enum logic [1:0] {
      OP_BEGIN  = 2'd0,
      OP_HEADER = 2'd1,
      OP_BYTE   = 2'd2
   } op_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] value;
      logic                         clamped;
   } coord_res_type;

endpackage
`default_nettype wire

// File: design/bfgr_coord_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module bfgr_coord_unit (
   input  wire logic signed [bfgr_pkg::COORD_BITS-1:0] base,
   input  wire logic signed [7:0]                      offset,
   input  wire logic        [7:0]                      count,
   output bfgr_pkg::coord_res_type                     result
);
   import bfgr_pkg::*;

   logic signed [SUM_BITS-1:0] sum;

   assign sum = SUM_BITS'(base) + SUM_BITS'(offset) + $signed(SUM_BITS'({1'b0, count}));

   always_comb begin
      if (sum > SUM_HI) begin
         result.value   = COORD_HI_CODE;
         result.clamped = 1'b1;
      end else if (sum < SUM_LO) begin
         result.value   = COORD_LO_CODE;
         result.clamped = 1'b1;
      end else begin
         result.value   = sum[COORD_BITS-1:0];
         result.clamped = 1'b0;
      end
   end

endmodule
`default_nettype wire

// File: design/bitmap_font_glyph_rasterizer.sv
`timescale 1ns / 1ps
`default_nettype none
// Rasterizes 1-bit-per-pixel glyph bitmaps into a stream of lit pixels. An item
// is a begin (pen, baseline, colour), a glyph header (size, offsets, advance) or
// a bitmap byte, MSB first, rows packed without padding. req_stall is high until
// an item is done. A header first advances the pen past an open glyph, and one
// with zero width or height advances it again; each pen advance goes through the
// adder. A byte with no glyph open is dropped; otherwise its bits are scanned in
// turn, and a single clamping coordinate adder computes x and then y of every
// pixel. When the glyph ends the pen advances and the rest of the byte is
// dropped; the scan waits while the result side stalls. Each pixel is held back
// until the next lit bit or the end of the byte is found, so that the last pixel
// of a byte can be marked; rsp_last is set on it.
module bitmap_font_glyph_rasterizer (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic        [1:0]                      req_op,
   input  wire logic signed [bfgr_pkg::COORD_BITS-1:0] req_pos_x,
   input  wire logic signed [bfgr_pkg::COORD_BITS-1:0] req_pos_y,
   input  wire logic        [bfgr_pkg::COLOR_BITS-1:0] req_ink_color,
   input  wire logic        [7:0]                      req_glyph_width,
   input  wire logic        [7:0]                      req_glyph_height,
   input  wire logic signed [7:0]                      req_x_offset,
   input  wire logic signed [7:0]                      req_y_offset,
   input  wire logic        [7:0]                      req_x_advance,
   input  wire logic        [7:0]                      req_data_byte,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic signed      [bfgr_pkg::COORD_BITS-1:0] rsp_pixel_x,
   output logic signed      [bfgr_pkg::COORD_BITS-1:0] rsp_pixel_y,
   output logic             [bfgr_pkg::COLOR_BITS-1:0] rsp_pixel_color,
   output logic                                        rsp_off_range,
   output logic                                        rsp_last
);
   import bfgr_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ADV_OLD,
      ST_LOAD_HDR,
      ST_ADV_NEW,
      ST_BIT,
      ST_CALC_X,
      ST_CALC_Y,
      ST_ADV_END,
      ST_FLUSH
   } state_type;

   state_type state_ff;

   // Latched item.
   logic        [1:0]            op_ff;
   logic signed [COORD_BITS-1:0] item_x_ff;
   logic signed [COORD_BITS-1:0] item_y_ff;
   logic        [COLOR_BITS-1:0] item_color_ff;
   logic        [7:0]            item_width_ff;
   logic        [7:0]            item_height_ff;
   logic signed [7:0]            item_xoff_ff;
   logic signed [7:0]            item_yoff_ff;
   logic        [7:0]            item_advance_ff;
   logic        [7:0]            byte_ff;
   logic        [2:0]            bit_idx_ff;

   // Run and glyph state.
   logic signed [COORD_BITS-1:0] pen_x_ff;
   logic signed [COORD_BITS-1:0] base_y_ff;
   logic        [COLOR_BITS-1:0] cur_color_ff;
   logic        [7:0]            cur_width_ff;
   logic        [7:0]            cur_height_ff;
   logic signed [7:0]            cur_xoff_ff;
   logic signed [7:0]            cur_yoff_ff;
   logic        [7:0]            cur_advance_ff;
   logic        [7:0]            col_count_ff;
   logic        [7:0]            row_count_ff;
   logic                         glyph_open_ff;

   // Pixel x computed in the first pass, and the held-back pixel.
   logic signed [COORD_BITS-1:0] calc_x_ff;
   logic                         calc_flag_ff;
   logic                         hold_valid_ff;
   logic signed [COORD_BITS-1:0] hold_x_ff;
   logic signed [COORD_BITS-1:0] hold_y_ff;
   logic                         hold_flag_ff;

   // Output register.
   logic                         rsp_valid_ff;
   logic signed [COORD_BITS-1:0] rsp_x_ff;
   logic signed [COORD_BITS-1:0] rsp_y_ff;
   logic        [COLOR_BITS-1:0] rsp_color_ff;
   logic                         rsp_flag_ff;
   logic                         rsp_last_ff;

   logic signed [COORD_BITS-1:0] unit_base;
   logic signed [7:0]            unit_offset;
   logic        [7:0]            unit_count;
   coord_res_type                unit_res;

   logic [8:0] col_next;
   logic [8:0] row_next;
   logic       col_wrap;
   logic       glyph_done;
   logic       out_free;
   logic       rsp_load;
   logic       bit_lit;
   logic       req_accept;

   bfgr_coord_unit u_coord (
      .base   (unit_base),
      .offset (unit_offset),
      .count  (unit_count),
      .result (unit_res)
   );

   // Operand selection for the shared adder. A pen advance is the same sum
   // with a zero offset; the pen never falls below the range, so only the
   // upper clamp can apply.
   always_comb begin
      case (state_ff)
         ST_CALC_X: begin
            unit_base   = pen_x_ff;
            unit_offset = cur_xoff_ff;
            unit_count  = col_count_ff;
         end
         ST_CALC_Y: begin
            unit_base   = base_y_ff;
            unit_offset = cur_yoff_ff;
            unit_count  = row_count_ff;
         end
         default: begin
            unit_base   = pen_x_ff;
            unit_offset = 8'sd0;
            unit_count  = cur_advance_ff;
         end
      endcase
   end

   assign col_next   = {1'b0, col_count_ff} + 9'd1;
   assign row_next   = {1'b0, row_count_ff} + 9'd1;
   assign col_wrap   = col_next >= {1'b0, cur_width_ff};
   assign glyph_done = col_wrap && (row_next >= {1'b0, cur_height_ff});
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_load   = hold_valid_ff && out_free &&
                       (state_ff == ST_CALC_Y || state_ff == ST_FLUSH);
   assign bit_lit    = (byte_ff & BIT_MSB_MASK) != 8'h00;
   assign req_stall  = state_ff != ST_IDLE;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         hold_valid_ff  <= 1'b0;
         pen_x_ff       <= '0;
         base_y_ff      <= '0;
         cur_color_ff   <= '0;
         cur_width_ff   <= '0;
         cur_height_ff  <= '0;
         cur_xoff_ff    <= '0;
         cur_yoff_ff    <= '0;
         cur_advance_ff <= '0;
         col_count_ff   <= '0;
         row_count_ff   <= '0;
         glyph_open_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  op_ff           <= req_op;
                  item_x_ff       <= req_pos_x;
                  item_y_ff       <= req_pos_y;
                  item_color_ff   <= req_ink_color;
                  item_width_ff   <= req_glyph_width;
                  item_height_ff  <= req_glyph_height;
                  item_xoff_ff    <= req_x_offset;
                  item_yoff_ff    <= req_y_offset;
                  item_advance_ff <= req_x_advance;
                  byte_ff         <= req_data_byte;
                  bit_idx_ff      <= 3'd0;
                  state_ff        <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               case (op_ff)
                  OP_BEGIN: begin
                     pen_x_ff      <= item_x_ff;
                     base_y_ff     <= item_y_ff;
                     cur_color_ff  <= item_color_ff;
                     glyph_open_ff <= 1'b0;
                     col_count_ff  <= '0;
                     row_count_ff  <= '0;
                     state_ff      <= ST_IDLE;
                  end
                  OP_HEADER: begin
                     state_ff <= glyph_open_ff ? ST_ADV_OLD : ST_LOAD_HDR;
                  end
                  OP_BYTE: begin
                     state_ff <= glyph_open_ff ? ST_BIT : ST_IDLE;
                  end
                  default: begin
                     state_ff <= ST_IDLE;
                  end
               endcase
            end
            ST_ADV_OLD: begin
               pen_x_ff <= unit_res.value;
               state_ff <= ST_LOAD_HDR;
            end
            ST_LOAD_HDR: begin
               cur_width_ff   <= item_width_ff;
               cur_height_ff  <= item_height_ff;
               cur_xoff_ff    <= item_xoff_ff;
               cur_yoff_ff    <= item_yoff_ff;
               cur_advance_ff <= item_advance_ff;
               col_count_ff   <= '0;
               row_count_ff   <= '0;
               if (item_width_ff == 8'd0 || item_height_ff == 8'd0) begin
                  glyph_open_ff <= 1'b0;
                  state_ff      <= ST_ADV_NEW;
               end else begin
                  glyph_open_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            ST_ADV_NEW: begin
               pen_x_ff <= unit_res.value;
               state_ff <= ST_IDLE;
            end
            ST_BIT, ST_CALC_Y: begin
               if (state_ff == ST_BIT && bit_lit) begin
                  state_ff <= ST_CALC_X;
               end else if (state_ff == ST_BIT || !hold_valid_ff || out_free) begin
                  if (state_ff == ST_CALC_Y) begin
                     // The earlier pixel is not the last of this byte.
                     if (hold_valid_ff) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_x_ff     <= hold_x_ff;
                        rsp_y_ff     <= hold_y_ff;
                        rsp_color_ff <= cur_color_ff;
                        rsp_flag_ff  <= hold_flag_ff;
                        rsp_last_ff  <= 1'b0;
                     end
                     hold_valid_ff <= 1'b1;
                     hold_x_ff     <= calc_x_ff;
                     hold_y_ff     <= unit_res.value;
                     hold_flag_ff  <= calc_flag_ff | unit_res.clamped;
                  end
                  // Step the column and row counters past this bit.
                  if (col_wrap) begin
                     col_count_ff <= '0;
                     row_count_ff <= glyph_done ? 8'd0 : row_next[7:0];
                  end else begin
                     col_count_ff <= col_next[7:0];
                  end
                  if (glyph_done) begin
                     glyph_open_ff <= 1'b0;
                     state_ff      <= ST_ADV_END;
                  end else if (bit_idx_ff == LAST_BIT_IDX) begin
                     state_ff <= ST_FLUSH;
                  end else begin
                     bit_idx_ff <= bit_idx_ff + 3'd1;
                     byte_ff    <= {byte_ff[6:0], 1'b0};
                     state_ff   <= ST_BIT;
                  end
               end
            end
            ST_CALC_X: begin
               calc_x_ff    <= unit_res.value;
               calc_flag_ff <= unit_res.clamped;
               state_ff     <= ST_CALC_Y;
            end
            ST_ADV_END: begin
               pen_x_ff <= unit_res.value;
               state_ff <= ST_FLUSH;
            end
            ST_FLUSH: begin
               if (!hold_valid_ff) begin
                  state_ff <= ST_IDLE;
               end else if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_x_ff      <= hold_x_ff;
                  rsp_y_ff      <= hold_y_ff;
                  rsp_color_ff  <= cur_color_ff;
                  rsp_flag_ff   <= hold_flag_ff;
                  rsp_last_ff   <= 1'b1;
                  hold_valid_ff <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_x_ff;
   assign rsp_pixel_y     = rsp_y_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_off_range   = rsp_flag_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
`default_nettype wire
